@@ hw/rtl/mbrx_pkg.sv @@
// Shared types, constants and the CRC-16 byte step for the Modbus RTU frame receiver.
package mbrx_pkg;

  // Frame status codes reported with every result byte.
  typedef enum logic [2:0] {
    ST_BUSY          = 3'd0,
    ST_OK            = 3'd1,
    ST_CRC_BAD       = 3'd2,
    ST_UNIT_MISMATCH = 3'd3,
    ST_UNEXPECTED    = 3'd4,
    ST_UNKNOWN_FUNC  = 3'd5
  } mbrx_status_t;

  // Configuration register indexes.
  typedef enum logic [1:0] {
    CFG_ROLE          = 2'd0,
    CFG_OWN_UNIT      = 2'd1,
    CFG_EXPECTED_FUNC = 2'd2
  } mbrx_cfg_idx_t;

  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned POS_W     = 9;

  localparam logic ROLE_MASTER = 1'b1;

  // Function codes with a length rule.
  localparam logic [7:0] FC_READ_COILS       = 8'd1;
  localparam logic [7:0] FC_READ_INPUT_REGS  = 8'd4;
  localparam logic [7:0] FC_WRITE_SINGLE_COIL = 8'd5;
  localparam logic [7:0] FC_WRITE_SINGLE_REG = 8'd6;
  localparam logic [7:0] FC_WRITE_MULTI_COILS = 8'd15;
  localparam logic [7:0] FC_WRITE_MULTI_REGS = 8'd16;
  localparam logic [7:0] FC_EXCEPTION_BIT    = 8'h80;

  // Frame lengths and the byte positions that carry length information.
  localparam logic [POS_W-1:0] LEN_UNKNOWN        = 9'd0;
  localparam logic [POS_W-1:0] LEN_EXCEPTION      = 9'd5;
  localparam logic [POS_W-1:0] LEN_FIXED          = 9'd8;
  localparam logic [POS_W-1:0] LEN_READ_RSP_BASE  = 9'd5;
  localparam logic [POS_W-1:0] LEN_WRITE_REQ_BASE = 9'd9;
  localparam logic [POS_W-1:0] POS_ADDR           = 9'd0;
  localparam logic [POS_W-1:0] POS_FUNC           = 9'd1;
  localparam logic [POS_W-1:0] POS_RSP_COUNT      = 9'd2;
  localparam logic [POS_W-1:0] POS_REQ_COUNT      = 9'd6;

  localparam logic [15:0] CRC_INIT = 16'hFFFF;
  localparam logic [15:0] CRC_POLY = 16'hA001;

  typedef struct packed {
    logic       role;
    logic [7:0] own_unit;
    logic [7:0] expected_function;
  } mbrx_cfg_t;

  typedef struct packed {
    logic [7:0]       data_byte;
    logic [POS_W-1:0] byte_position;
    logic             is_pdu;
    logic             frame_end;
    mbrx_status_t     status;
  } mbrx_result_t;

  // Reflected CRC-16 update over one byte, all eight bit steps unrolled.
  function automatic logic [15:0] crc16_byte(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {8'h00, b};
    for (int k = 0; k < 8; k++) begin
      c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    end
    return c;
  endfunction

endpackage

@@ hw/rtl/mbrx_cfg_regs.sv @@
// Configuration registers of the Modbus RTU frame receiver.
module mbrx_cfg_regs
  import mbrx_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 wr_en,
  input  logic [CFG_IDX_W-1:0] wr_index,
  input  logic [7:0]           wr_data,
  output mbrx_cfg_t            cfg
);

  mbrx_cfg_t cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.role              <= 1'b0;
      cfg_r.own_unit          <= 8'd1;
      cfg_r.expected_function <= 8'd3;
    end else if (wr_en) begin
      case (wr_index)
        CFG_ROLE:          cfg_r.role              <= wr_data[0];
        CFG_OWN_UNIT:      cfg_r.own_unit          <= wr_data;
        CFG_EXPECTED_FUNC: cfg_r.expected_function <= wr_data;
        default: ;
      endcase
    end
  end

  assign cfg = cfg_r;

endmodule

@@ hw/rtl/mbrx_parser.sv @@
// Frame state and per-byte parsing: length rules, running CRC and end-of-frame checks.
module mbrx_parser
  import mbrx_pkg::*;
(
  input  logic         clk,
  input  logic         rst_n,
  input  logic         step,
  input  logic         cmd,
  input  logic [7:0]   rx_byte,
  input  mbrx_cfg_t    cfg,
  output mbrx_result_t result
);

  logic [POS_W-1:0] pos_r,  pos_nxt;
  logic [15:0]      crc_r,  crc_nxt;
  logic [7:0]       func_r, func_nxt;
  logic [POS_W-1:0] len_r,  len_nxt;
  logic [7:0]       unit_r, unit_nxt;

  logic [15:0]      crc_upd;
  logic [7:0]       func_upd;
  logic [7:0]       unit_upd;
  logic [POS_W-1:0] len_upd;
  logic             unknown_fn;
  logic             last_byte;
  logic             pdu;
  logic             restart;
  mbrx_status_t     status;

  always_comb begin
    crc_upd    = crc16_byte(crc_r, rx_byte);
    func_upd   = func_r;
    unit_upd   = unit_r;
    len_upd    = len_r;
    unknown_fn = 1'b0;

    if (pos_r == POS_ADDR) begin
      unit_upd = rx_byte;
    end else if (pos_r == POS_FUNC) begin
      func_upd = rx_byte;
      if (cfg.role == ROLE_MASTER) begin
        if ((rx_byte & FC_EXCEPTION_BIT) != 8'd0) begin
          len_upd = LEN_EXCEPTION;
        end else if (rx_byte inside {[FC_READ_COILS:FC_READ_INPUT_REGS]}) begin
          len_upd = LEN_UNKNOWN;
        end else if (rx_byte inside {FC_WRITE_SINGLE_COIL, FC_WRITE_SINGLE_REG,
                                     FC_WRITE_MULTI_COILS, FC_WRITE_MULTI_REGS}) begin
          len_upd = LEN_FIXED;
        end else begin
          unknown_fn = 1'b1;
        end
      end else begin
        if (rx_byte inside {[FC_READ_COILS:FC_WRITE_SINGLE_REG]}) begin
          len_upd = LEN_FIXED;
        end else if (rx_byte inside {FC_WRITE_MULTI_COILS, FC_WRITE_MULTI_REGS}) begin
          len_upd = LEN_UNKNOWN;
        end else begin
          unknown_fn = 1'b1;
        end
      end
    end else if (len_r == LEN_UNKNOWN) begin
      // The byte count field fixes the length of variable frames.
      if (cfg.role == ROLE_MASTER && pos_r == POS_RSP_COUNT) begin
        len_upd = LEN_READ_RSP_BASE + {1'b0, rx_byte};
      end else if (cfg.role != ROLE_MASTER && pos_r == POS_REQ_COUNT) begin
        len_upd = LEN_WRITE_REQ_BASE + {1'b0, rx_byte};
      end
    end

    pdu = (pos_r != POS_ADDR) &&
          ((len_upd == LEN_UNKNOWN) || (({1'b0, pos_r} + 10'd2) < {1'b0, len_upd}));
    last_byte = !unknown_fn && (len_upd != LEN_UNKNOWN) &&
                (({1'b0, pos_r} + 10'd1) >= {1'b0, len_upd});

    if (unknown_fn) begin
      status = ST_UNKNOWN_FUNC;
    end else if (last_byte) begin
      if (crc_upd != 16'd0) begin
        status = ST_CRC_BAD;
      end else if (unit_upd != cfg.own_unit) begin
        status = ST_UNIT_MISMATCH;
      end else if (cfg.role == ROLE_MASTER && func_upd != cfg.expected_function &&
                   func_upd != (cfg.expected_function | FC_EXCEPTION_BIT)) begin
        status = ST_UNEXPECTED;
      end else begin
        status = ST_OK;
      end
    end else begin
      status = ST_BUSY;
    end

    if (cmd) begin
      result = '{data_byte: 8'd0, byte_position: '0, is_pdu: 1'b0,
                 frame_end: 1'b0, status: ST_BUSY};
    end else begin
      result = '{data_byte: rx_byte, byte_position: pos_r, is_pdu: pdu,
                 frame_end: unknown_fn | last_byte, status: status};
    end

    restart = cmd || unknown_fn || last_byte;
    if (restart) begin
      pos_nxt  = '0;
      crc_nxt  = CRC_INIT;
      func_nxt = 8'd0;
      len_nxt  = LEN_UNKNOWN;
      unit_nxt = 8'd0;
    end else begin
      pos_nxt  = pos_r + 9'd1;
      crc_nxt  = crc_upd;
      func_nxt = func_upd;
      len_nxt  = len_upd;
      unit_nxt = unit_upd;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r  <= '0;
      crc_r  <= CRC_INIT;
      func_r <= 8'd0;
      len_r  <= LEN_UNKNOWN;
      unit_r <= 8'd0;
    end else if (step) begin
      pos_r  <= pos_nxt;
      crc_r  <= crc_nxt;
      func_r <= func_nxt;
      len_r  <= len_nxt;
      unit_r <= unit_nxt;
    end
  end

endmodule

@@ hw/rtl/modbus_rtu_frame_receiver_top.sv @@
// Top level of the Modbus RTU frame receiver: input register, parser and result register.
//
// Received bytes enter one per transaction and are cut into Modbus RTU frames; each
// byte comes back as one result carrying the byte, its position in the frame, a PDU
// flag, an end-of-frame flag and a status (CRC, unit address and, in the master role,
// function match are checked on the last byte). The block takes one byte per clock
// cycle while results are taken. A byte is held in the input register while the
// parser's CRC byte step and length logic work on it, and its result is loaded into
// the result register and offered there until it is taken. While a
// result waits to be taken, the input register can still take one more byte; after
// that the input stalls until the result leaves. Configuration writes are taken in
// every cycle and should only be issued while no byte is in flight.
module modbus_rtu_frame_receiver_top
  import mbrx_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic                 in_cmd,
  input  logic [7:0]           in_rx_byte,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [7:0]           out_data_byte,
  output logic [POS_W-1:0]     out_byte_position,
  output logic                 out_is_pdu,
  output logic                 out_frame_end,
  output logic [2:0]           out_status,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [7:0]           cfg_data
);

  mbrx_cfg_t    cfg;
  mbrx_result_t result;
  mbrx_result_t out_r;

  logic       in_vld_r;
  logic       in_cmd_r;
  logic [7:0] in_byte_r;
  logic       out_vld_r;
  logic       advance;
  logic       fire;

  assign cfg_ready = 1'b1;

  mbrx_cfg_regs u_cfg (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_en    (cfg_valid & cfg_ready),
    .wr_index (cfg_index),
    .wr_data  (cfg_data),
    .cfg      (cfg)
  );

  // The result register frees up when it is empty or its transaction completes.
  assign advance  = !out_vld_r || out_ready;
  assign fire     = in_vld_r && advance;
  assign in_ready = !in_vld_r || advance;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else if (in_ready) begin
      in_vld_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      in_cmd_r  <= in_cmd;
      in_byte_r <= in_rx_byte;
    end
  end

  mbrx_parser u_parser (
    .clk     (clk),
    .rst_n   (rst_n),
    .step    (fire),
    .cmd     (in_cmd_r),
    .rx_byte (in_byte_r),
    .cfg     (cfg),
    .result  (result)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (advance) begin
      out_vld_r <= in_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      out_r <= result;
    end
  end

  assign out_valid         = out_vld_r;
  assign out_data_byte     = out_r.data_byte;
  assign out_byte_position = out_r.byte_position;
  assign out_is_pdu        = out_r.is_pdu;
  assign out_frame_end     = out_r.frame_end;
  assign out_status        = out_r.status;

endmodule

@@ hw/rtl/mbrx_checker.sv @@
// Port-level assertions for the Modbus RTU frame receiver and their bind to the top level.
module mbrx_checker
  import mbrx_pkg::*;
(
  input logic                 clk,
  input logic                 rst_n,
  input logic                 out_valid,
  input logic                 out_ready,
  input logic [7:0]           out_data_byte,
  input logic [POS_W-1:0]     out_byte_position,
  input logic                 out_is_pdu,
  input logic                 out_frame_end,
  input logic [2:0]           out_status
);

  // Reset empties the result register.
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid after reset");

  // A frame ends exactly when a final status is reported.
  a_end_status: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_frame_end == (out_status != ST_BUSY)))
    else $error("frame_end and status disagree");

  // The address byte never belongs to the PDU.
  a_addr_not_pdu: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_byte_position == POS_ADDR |-> !out_is_pdu)
    else $error("address byte marked as PDU");

  // A stalled result holds its payload.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data_byte) &&
      $stable(out_byte_position) && $stable(out_status))
    else $error("stalled result changed");

endmodule

bind modbus_rtu_frame_receiver_top mbrx_checker u_mbrx_checker (.*);

@@ tb/sv/modbus_rtu_frame_receiver_checker.sv @@
// Result checker for the Modbus RTU frame receiver, with the CRC helper the stimulus shares.
package mbrx_tb_pkg;
  import mbrx_pkg::*;

  // Bit-serial form of the reflected CRC-16: one data bit enters at the low end per step.
  function automatic logic [15:0] crc16_step(input logic [15:0] acc, input logic [7:0] d);
    logic [15:0] r;
    r = acc;
    for (int i = 0; i < 8; i++) begin
      r = (r >> 1) ^ ((r[0] ^ d[i]) ? CRC_POLY : 16'h0000);
    end
    return r;
  endfunction
endpackage

module modbus_rtu_frame_receiver_checker
  import mbrx_pkg::*;
  import mbrx_tb_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  input  logic                 in_ready,
  input  logic                 in_cmd,
  input  logic [7:0]           in_rx_byte,
  input  logic                 out_valid,
  input  logic                 out_ready,
  input  logic [7:0]           out_data_byte,
  input  logic [POS_W-1:0]     out_byte_position,
  input  logic                 out_is_pdu,
  input  logic                 out_frame_end,
  input  logic [2:0]           out_status,
  input  logic                 cfg_valid,
  input  logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [7:0]           cfg_data,
  output int                   fail_count,
  output int                   pending
);

  mbrx_cfg_t        cfg_q;
  logic [POS_W-1:0] pos_q;
  logic [POS_W-1:0] len_q;
  logic [15:0]      crc_q;
  logic [7:0]       func_q;
  logic [7:0]       unit_q;

  mbrx_result_t expected_bytes[$];
  int fails  = 0;
  int queued = 0;

  assign fail_count = fails;
  assign pending    = queued;

  task automatic clear_frame();
    pos_q  = '0;
    crc_q  = CRC_INIT;
    func_q = '0;
    len_q  = LEN_UNKNOWN;
    unit_q = '0;
  endtask

  task automatic predict_byte(input logic cmd, input logic [7:0] b, output mbrx_result_t r);
    int           p;
    int           flen;
    mbrx_status_t st;
    logic         fin;
    r   = '0;
    p   = pos_q;
    st  = ST_BUSY;
    fin = 1'b0;
    if (cmd) begin
      clear_frame();
      return;
    end
    crc_q = crc16_step(crc_q, b);
    if (p == POS_ADDR) begin
      unit_q = b;
    end else if (p == POS_FUNC) begin
      func_q = b;
      if (cfg_q.role == ROLE_MASTER) begin
        if ((b & FC_EXCEPTION_BIT) != 0) len_q = LEN_EXCEPTION;
        else if (b >= FC_READ_COILS && b <= FC_READ_INPUT_REGS) len_q = LEN_UNKNOWN;
        else if (b == FC_WRITE_SINGLE_COIL || b == FC_WRITE_SINGLE_REG ||
                 b == FC_WRITE_MULTI_COILS || b == FC_WRITE_MULTI_REGS) len_q = LEN_FIXED;
        else st = ST_UNKNOWN_FUNC;
      end else begin
        if (b >= FC_READ_COILS && b <= FC_WRITE_SINGLE_REG) len_q = LEN_FIXED;
        else if (b == FC_WRITE_MULTI_COILS || b == FC_WRITE_MULTI_REGS) len_q = LEN_UNKNOWN;
        else st = ST_UNKNOWN_FUNC;
      end
    end else if (len_q == LEN_UNKNOWN) begin
      // The byte count fixes the length: byte 2 of a read response, byte 6 of a write request.
      if (cfg_q.role == ROLE_MASTER && p == POS_RSP_COUNT) len_q = LEN_READ_RSP_BASE + b;
      else if (cfg_q.role != ROLE_MASTER && p == POS_REQ_COUNT) len_q = LEN_WRITE_REQ_BASE + b;
    end
    flen = len_q;
    r.is_pdu = (p >= 1 && (flen == 0 || p + 2 < flen));
    if (st == ST_UNKNOWN_FUNC) begin
      fin = 1'b1;
    end else if (flen != 0 && p + 1 >= flen) begin
      fin = 1'b1;
      if (crc_q != 16'h0000) st = ST_CRC_BAD;
      else if (unit_q != cfg_q.own_unit) st = ST_UNIT_MISMATCH;
      else if (cfg_q.role == ROLE_MASTER && func_q != cfg_q.expected_function &&
               func_q != (cfg_q.expected_function | FC_EXCEPTION_BIT)) st = ST_UNEXPECTED;
      else st = ST_OK;
    end
    r.data_byte     = b;
    r.byte_position = p[POS_W-1:0];
    r.frame_end     = fin;
    r.status        = st;
    if (fin) clear_frame();
    else pos_q = pos_q + 1'b1;
  endtask

  task automatic check_field(input string name, input logic [8:0] want, input logic [8:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
      fails++;
    end
  endtask

  always @(posedge clk) begin : monitor
    mbrx_result_t want;
    if (!rst_n) begin
      cfg_q.role              = 1'b0;
      cfg_q.own_unit          = 8'd1;
      cfg_q.expected_function = 8'd3;
      clear_frame();
      expected_bytes.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_ROLE:          cfg_q.role = cfg_data[0];
          CFG_OWN_UNIT:      cfg_q.own_unit = cfg_data;
          CFG_EXPECTED_FUNC: cfg_q.expected_function = cfg_data;
          default: ;
        endcase
      end
      if (in_valid && in_ready) begin
        predict_byte(in_cmd, in_rx_byte, want);
        expected_bytes.insert(expected_bytes.size(), want);
      end
      if (out_valid && out_ready) begin
        if (expected_bytes.size() == 0) begin
          $display("%0t: unexpected result transaction, expected none, actual byte %0h pos %0d",
                   $time, out_data_byte, out_byte_position);
          fails++;
        end else begin
          want = expected_bytes.pop_front();
          check_field("data_byte", want.data_byte, out_data_byte);
          check_field("byte_position", want.byte_position, out_byte_position);
          check_field("is_pdu", want.is_pdu, out_is_pdu);
          check_field("frame_end", want.frame_end, out_frame_end);
          check_field("status", want.status, out_status);
        end
      end
    end
    queued = expected_bytes.size();
  end

endmodule

@@ tb/sv/modbus_rtu_frame_receiver_top_tb.sv @@
// Testbench top for the Modbus RTU frame receiver: clock, reset, frame stimulus and verdict.
module modbus_rtu_frame_receiver_top_tb;
  import mbrx_pkg::*;
  import mbrx_tb_pkg::*;

  localparam int CYCLE_LIMIT  = 400000;
  localparam int RANDOM_ITEMS = 1700;
  localparam int PHASE_ITEMS  = 150;
  localparam int HOLD_CYCLES  = 400;
  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED_IDX = 2'd3;

  logic                 clk;
  logic                 rst_n       = 1'b0;
  logic                 in_valid    = 1'b0;
  logic                 in_ready;
  logic                 in_cmd      = 1'b0;
  logic [7:0]           in_rx_byte  = 8'h00;
  logic                 out_valid;
  logic                 out_ready   = 1'b0;
  logic [7:0]           out_data_byte;
  logic [POS_W-1:0]     out_byte_position;
  logic                 out_is_pdu;
  logic                 out_frame_end;
  logic [2:0]           out_status;
  logic                 cfg_valid   = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index   = '0;
  logic [7:0]           cfg_data    = 8'h00;
  int                   fail_count;
  int                   pending;

  int   cycles    = 0;
  int   items_sent = 0;
  int   hold_left = 0;
  bit   hold_req  = 1'b0;
  bit   hold_taken = 1'b0;
  bit   no_idle   = 1'b0;
  logic       cur_role;
  logic [7:0] cur_own;
  logic [7:0] cur_exp;

  modbus_rtu_frame_receiver_top i_dut (.*);

  modbus_rtu_frame_receiver_checker i_checker (.*);

  always begin
    clk = 1'b1;
    #1;
    clk = 1'b0;
    #1;
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  // Receiver side: random back-pressure, plus one long hold-off when requested.
  always @(negedge clk) begin
    if (hold_req && !hold_taken) begin
      hold_left  = HOLD_CYCLES;
      hold_taken = 1'b1;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_ready = 1'b0;
    end else begin
      out_ready = no_idle || ($urandom_range(99) >= 36);
    end
  end

  function automatic logic [7:0] pick_fn();
    int unsigned k;
    k = $urandom_range(7);
    if (k < 6) return FC_READ_COILS + 8'(k);
    return (k == 6) ? FC_WRITE_MULTI_COILS : FC_WRITE_MULTI_REGS;
  endfunction

  // Called at a falling edge; returns at the falling edge after the transaction.
  task automatic send_byte(input logic cmd, input logic [7:0] b);
    while (!no_idle && $urandom_range(99) < 36) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_valid   = 1'b1;
    in_cmd     = cmd;
    in_rx_byte = b;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    @(negedge clk);
    in_valid = 1'b0;
    items_sent++;
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [7:0] data);
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_data  = data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  task automatic wait_idle();
    while (pending != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  // Builds a frame with a correct CRC; flip_at corrupts one bit, cut_at aborts with a restart.
  task automatic send_frame(input logic master, input logic [7:0] unit, input logic [7:0] fn,
                            input int cnt, input int flip_at, input int cut_at);
    logic [7:0]  q[$];
    logic [15:0] c;
    int          n;
    q.insert(q.size(), unit);
    q.insert(q.size(), fn);
    if (master) begin
      if ((fn & FC_EXCEPTION_BIT) != 0) begin
        q.insert(q.size(), 8'($urandom));
      end else if (fn >= FC_READ_COILS && fn <= FC_READ_INPUT_REGS) begin
        q.insert(q.size(), 8'(cnt));
        repeat (cnt) q.insert(q.size(), 8'($urandom));
      end else begin
        repeat (4) q.insert(q.size(), 8'($urandom));
      end
    end else begin
      repeat (4) q.insert(q.size(), 8'($urandom));
      if (fn == FC_WRITE_MULTI_COILS || fn == FC_WRITE_MULTI_REGS) begin
        q.insert(q.size(), 8'(cnt));
        repeat (cnt) q.insert(q.size(), 8'($urandom));
      end
    end
    c = CRC_INIT;
    for (int k = 0; k < q.size(); k++) c = crc16_step(c, q[k]);
    q.insert(q.size(), c[7:0]);
    q.insert(q.size(), c[15:8]);
    if (flip_at >= 0 && flip_at < q.size()) q[flip_at] = q[flip_at] ^ (8'h01 << $urandom_range(7));
    n = (cut_at >= 0 && cut_at < q.size()) ? cut_at : q.size();
    for (int k = 0; k < n; k++) send_byte(1'b0, q[k]);
    if (n < q.size()) send_byte(1'b1, 8'($urandom));
  endtask

  task automatic random_frame();
    int unsigned kind;
    logic [7:0]  unit;
    logic [7:0]  fn;
    int          cnt;
    int unsigned r;
    kind = $urandom_range(99);
    unit = ($urandom_range(9) == 0) ? 8'($urandom) : cur_own;
    fn   = pick_fn();
    if (cur_role == ROLE_MASTER) begin
      case ($urandom_range(3))
        0: fn = cur_exp;
        1: fn = cur_exp | FC_EXCEPTION_BIT;
        2: fn = fn | FC_EXCEPTION_BIT;
        default: ;
      endcase
    end
    // Mostly short data blocks, now and then up to the largest byte count.
    r   = $urandom_range(99);
    cnt = (r < 3) ? 255 : (r < 10) ? $urandom_range(255) : $urandom_range(8);
    if (kind < 62) begin
      send_frame(cur_role, unit, fn, cnt, -1, -1);
    end else if (kind < 76) begin
      send_frame(cur_role, unit, fn, cnt, $urandom_range(7), -1);
    end else if (kind < 83) begin
      send_frame(cur_role, unit, fn, cnt, -1, $urandom_range(6));
    end else if (kind < 89) begin
      send_frame(!cur_role, unit, pick_fn(), cnt, -1, -1);
      if ($urandom_range(1) == 0) send_byte(1'b1, 8'($urandom));
    end else if (kind < 95) begin
      repeat ($urandom_range(1, 4)) send_byte(1'b0, 8'($urandom));
      if ($urandom_range(1) == 0) send_byte(1'b1, 8'($urandom));
    end else begin
      send_byte(1'b1, 8'($urandom));
    end
  endtask

  initial begin
    int directed_items;
    int phase;
    int phase_end;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    // Directed frames under the reset settings: slave, unit 1.
    send_frame(1'b0, 8'h01, FC_WRITE_SINGLE_REG, 0, -1, -1);
    send_frame(1'b0, 8'h01, FC_WRITE_MULTI_REGS, 0, -1, -1);
    send_frame(1'b0, 8'hFF, FC_READ_COILS, 0, -1, 3);
    send_byte(1'b0, 8'h00);
    send_byte(1'b0, 8'hFF);
    send_byte(1'b1, 8'hFF);
    directed_items = items_sent;

    phase = 0;
    while (items_sent - directed_items < RANDOM_ITEMS) begin
      wait_idle();
      cur_role = ~phase[0];
      case (phase % 4)
        0: cur_own = 8'h00;
        1: cur_own = 8'hFF;
        2: cur_own = 8'h01;
        default: cur_own = 8'($urandom);
      endcase
      case (phase % 5)
        0: cur_exp = 8'h00;
        1: cur_exp = 8'hFF;
        2: cur_exp = 8'($urandom);
        default: cur_exp = pick_fn();
      endcase
      if (phase % 3 == 1) write_reg(CFG_UNUSED_IDX, 8'($urandom));
      write_reg(CFG_EXPECTED_FUNC, cur_exp);
      write_reg(CFG_OWN_UNIT, cur_own);
      // Only bit 0 of the role register counts; the upper bits are noise.
      write_reg(CFG_ROLE, {7'($urandom), cur_role});
      @(negedge clk);

      no_idle = (phase == 2 || phase == 4);
      if (phase == 2) hold_req = 1'b1;
      if (phase == 2 || phase == 3) begin
        send_frame(cur_role, cur_own, (cur_role == ROLE_MASTER) ? FC_READ_COILS :
                   FC_WRITE_MULTI_COILS, 255, -1, -1);
      end
      phase_end = items_sent + PHASE_ITEMS;
      while (items_sent < phase_end) random_frame();
      no_idle = 1'b0;
      phase++;
    end

    wait_idle();
    repeat (10) @(negedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
